[hdl/hktqp_pkg.sv]
// Package: types, constants and mix constants for the quadratic-probe key table.
package hktqp_pkg;

   localparam int TableDepthDefault = 1024;
   localparam int MaxKeyBytesDefault = 8;
   localparam int ValueBitsDefault = 32;

   localparam logic [63:0] MIX_ADD = 64'hE654_6B64;
   localparam logic [63:0] MIX_MUL1 = 64'hCC9E_2D51;
   localparam logic [63:0] MIX_MUL2 = 64'h1B87_3593;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FOUND = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [63:0] key_bytes;
      logic [3:0]  key_length;
      logic [31:0] value_word;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  slot_index;
      logic [31:0] found_value;
      logic [10:0] stored_count;
   } rsp_type;

endpackage

[hdl/hashed_key_table_quadratic_probe.sv]
// Top level: hashed key table with quadratic probing over a single slot memory.
//
// One request at a time. Per request: key mask, one mix round per key byte (after clamping)
// (each 64x32 multiply is split into two 32x32 halves on one shared 32x32 multiplier),
// a bit-serial reduction of the 64-bit hash modulo the size in use S, then a probe walk over
// 1 to S slots, each visited with a memory read, then compare/write.
// The next request is taken in the cycle after the response is accepted at the earliest.
// After reset a clearing pass zeroes every slot before the first request is taken.
module hashed_key_table_quadratic_probe
#(
   parameter int TABLE_DEPTH = hktqp_pkg::TableDepthDefault,
   parameter int MAX_KEY_BYTES = hktqp_pkg::MaxKeyBytesDefault,
   parameter int VALUE_BITS = hktqp_pkg::ValueBitsDefault
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hktqp_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hktqp_pkg::rsp_type  rsp_data,
   input  logic                csr_write_enable,
   input  logic [10:0]         csr_write_data
);
   import hktqp_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = 1 + 64 + 4 + VALUE_BITS;
   localparam logic [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);
   localparam logic [3:0] MAXLEN = 4'(MAX_KEY_BYTES);

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_MASK = 4'd2, S_MA = 4'd3,
      S_M1L = 4'd4, S_M1H = 4'd5, S_ROT = 4'd6, S_M2L = 4'd7, S_M2H = 4'd8,
      S_MOD = 4'd9, S_RD = 4'd10, S_CMP = 4'd11, S_RSP = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [10:0] cfg_ff;
   req_type req_ff;
   logic [3:0] len_ff;
   logic [3:0] byte_ff;
   logic [63:0] h_ff, h_in, acc_ff, acc_in;
   logic [6:0] bit_ff;
   logic [SW-1:0] size_ff;
   logic [SW-1:0] rem_ff;
   logic [SW-1:0] q_ff, idx_ff, odd_ff;
   logic [SW-1:0] probes_ff;
   logic [10:0] count_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;
   // set in the cycle that finishes a mix round
   logic mix_fin_ff;

   logic [EW-1:0] mem [TABLE_DEPTH];
   logic [EW-1:0] rd_ff;
   logic mem_we;
   logic [AW-1:0] mem_wa;
   logic [EW-1:0] mem_wd;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff;
   logic [63:0] prod_sum;

   logic [SW-1:0] size_cfg;
   always_comb begin
      if (cfg_ff == 11'd0) size_cfg = SW'(1);
      else if (32'(cfg_ff) > 32'(TABLE_DEPTH)) size_cfg = DEPTH_S;
      else size_cfg = SW'(cfg_ff);
   end

   logic [7:0] cur_byte;
   assign cur_byte = req_ff.key_bytes[byte_ff[2:0]*8 +: 8];

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      unique case (state_ff)
         S_M1L: begin mul_a = h_ff[31:0]; mul_b = MIX_MUL1[31:0]; end
         S_M1H: begin mul_a = h_ff[63:32]; mul_b = MIX_MUL1[31:0]; end
         S_M2L: begin mul_a = h_ff[31:0]; mul_b = MIX_MUL2[31:0]; end
         S_M2H: begin mul_a = h_ff[63:32]; mul_b = MIX_MUL2[31:0]; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) prod_ff <= mul_a * mul_b;

   // low product plus the high-half product shifted up
   assign prod_sum = acc_ff + {prod_ff[31:0], 32'd0};

   logic slot_valid;
   logic key_match;
   logic probe_stop, probe_last;
   logic [SW:0] rem_shift, rem_next;
   logic [SW:0] idx_sum;
   logic [SW-1:0] idx_next, odd_next;
   logic [SW:0] odd_sum;
   assign slot_valid = rd_ff[EW-1];
   assign key_match = (rd_ff[VALUE_BITS +: 4] == len_ff) &&
                      (rd_ff[VALUE_BITS+4 +: 64] == req_ff.key_bytes);
   assign probe_stop = !slot_valid || (req_ff.operation == OP_LOOKUP && key_match);
   assign probe_last = (probes_ff + SW'(1) >= size_ff);
   assign rem_shift = {rem_ff, acc_ff[63]};
   assign rem_next = (rem_shift >= {1'b0, size_ff}) ? rem_shift - {1'b0, size_ff} : rem_shift;
   assign idx_sum = {1'b0, idx_ff} + {1'b0, odd_ff};
   assign idx_next = (idx_sum >= {1'b0, size_ff}) ? SW'(idx_sum - {1'b0, size_ff})
                                                  : idx_sum[SW-1:0];
   // offset step 2q+1 reduced mod S (subtracting S, or 2S when S is 1, keeps it in range)
   assign odd_sum = {1'b0, odd_ff} + (SW+1)'(2);
   always_comb begin
      odd_next = odd_sum[SW-1:0];
      if (odd_sum >= {1'b0, size_ff}) odd_next = SW'(odd_sum - {1'b0, size_ff});
      if (odd_sum >= {size_ff, 1'b0}) odd_next = SW'(odd_sum - {size_ff, 1'b0});
   end

   always_comb begin
      state_in = state_ff;
      h_in = h_ff;
      acc_in = acc_ff;
      unique case (state_ff)
         S_CLEAR: if (idx_ff == SW'(TABLE_DEPTH - 1)) state_in = S_IDLE;
         S_IDLE: if (req_valid) state_in = S_MASK;
         S_MASK: begin
            h_in = 64'd0;
            acc_in = 64'd0;
            state_in = (len_ff == 4'd0) ? S_MOD : S_MA;
         end
         S_MA: begin
            h_in = (((h_ff << 2) + h_ff + MIX_ADD) << 8) | {56'd0, cur_byte};
            state_in = S_M1L;
         end
         S_M1L: state_in = S_M1H;
         S_M1H: begin acc_in = prod_ff; state_in = S_ROT; end
         S_ROT: begin
            h_in = {prod_sum[48:0], 15'd0} | {17'd0, prod_sum[63:17]};
            state_in = S_M2L;
         end
         S_M2L: state_in = S_M2H;
         S_M2H: begin acc_in = prod_ff; state_in = S_MOD; end
         S_MOD: begin
            if (mix_fin_ff) begin
               h_in = prod_sum;
               if (byte_ff + 4'd1 < len_ff) state_in = S_MA;
               else acc_in = prod_sum;
            end else begin
               acc_in = {acc_ff[62:0], 1'b0};
               if (bit_ff == 7'd63) state_in = S_RD;
            end
         end
         S_RD: state_in = S_CMP;
         S_CMP: state_in = (probe_stop || probe_last) ? S_RSP : S_RD;
         S_RSP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cfg_ff <= 11'd1024;
         count_ff <= 11'd0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         mix_fin_ff <= 1'b0;
      end else begin
         if (csr_write_enable) cfg_ff <= csr_write_data;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         state_ff <= state_in;
         h_ff <= h_in;
         acc_ff <= acc_in;
         mix_fin_ff <= (state_ff == S_M2H);
         unique case (state_ff)
            S_CLEAR: idx_ff <= idx_ff + SW'(1);
            S_IDLE: if (req_valid) begin
               req_ff <= req_data;
               len_ff <= (req_data.key_length > MAXLEN) ? MAXLEN : req_data.key_length;
               size_ff <= size_cfg;
            end
            S_MASK: begin
               for (int i = 0; i < 8; i++)
                  if (i >= int'(len_ff)) req_ff.key_bytes[i*8 +: 8] <= 8'd0;
               if (VALUE_BITS < 32)
                  req_ff.value_word <= req_ff.value_word & ((32'd1 << VALUE_BITS) - 32'd1);
               byte_ff <= 4'd0;
               bit_ff <= 7'd0;
               rem_ff <= '0;
            end
            S_MOD: begin
               if (mix_fin_ff) begin
                  byte_ff <= byte_ff + 4'd1;
                  bit_ff <= 7'd0;
                  rem_ff <= '0;
               end else begin
                  rem_ff <= rem_next[SW-1:0];
                  bit_ff <= bit_ff + 7'd1;
                  if (bit_ff == 7'd63) begin
                     idx_ff <= rem_next[SW-1:0];
                     odd_ff <= SW'(1) >= size_ff ? '0 : SW'(1);
                     probes_ff <= '0;
                  end
               end
            end
            S_CMP: begin
               if (probe_stop) begin
                  rsp_valid_ff <= 1'b1;
                  if (!slot_valid && req_ff.operation == OP_INSERT) begin
                     count_ff <= count_ff + 11'd1;
                     rsp_ff <= '{ST_INSERTED, 10'(idx_ff), 32'd0, count_ff + 11'd1};
                  end else if (!slot_valid)
                     rsp_ff <= '{ST_NOT_FOUND, 10'd0, 32'd0, count_ff};
                  else
                     rsp_ff <= '{ST_FOUND, 10'(idx_ff), 32'(rd_ff[VALUE_BITS-1:0]), count_ff};
               end else if (probe_last) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{(req_ff.operation == OP_INSERT) ? ST_FULL : ST_NOT_FOUND,
                              10'd0, 32'd0, count_ff};
               end else begin
                  probes_ff <= probes_ff + SW'(1);
                  idx_ff <= idx_next;
                  odd_ff <= odd_next;
               end
            end
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign mem_we = (state_ff == S_CLEAR) ||
                   (state_ff == S_CMP && !slot_valid && req_ff.operation == OP_INSERT);
   assign mem_wa = AW'(idx_ff);
   assign mem_wd = (state_ff == S_CLEAR) ? '0 :
                   {1'b1, req_ff.key_bytes, len_ff, VALUE_BITS'(req_ff.value_word)};

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[AW'(idx_ff)];
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= TABLE_DEPTH) else $error("entry count over depth");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
   a_ready_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while response pending");
`endif

endmodule

[bench/hashed_key_table_quadratic_probe_test.sv]
// Testbench: random and directed inserts and lookups against a predicted quadratic-probe table.
`timescale 1ns / 1ps

module hashed_key_table_quadratic_probe_test;
   import hktqp_pkg::*;

   localparam int Depth = 1024;
   localparam int Settle = 3000;
   localparam longint CycleLimit = 10000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [10:0] csr_write_data = '0;

   hashed_key_table_quadratic_probe i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic        tbl_valid [Depth];
   logic [63:0] tbl_key [Depth];
   logic [3:0]  tbl_len [Depth];
   logic [31:0] tbl_value [Depth];
   int unsigned tbl_count;
   logic [10:0] slots_reg;

   req_type pending_requests[$];
   rsp_type expected_responses[$];
   int mismatches = 0;
   longint cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   bit hold_sender = 1'b0;
   bit drive_done = 1'b0;
   int stall_phase = 0;
   logic [63:0] recent_keys[$];
   logic [3:0] recent_lens[$];
   logic req_ready_seen = 1'b0;

   function automatic logic [63:0] mix_hash(logic [63:0] key, int len);
      logic [63:0] h;
      h = '0;
      for (int i = 0; i < len; i++) begin
         h = h * 64'd5 + MIX_ADD;
         h = h << 8;
         h = h | {56'd0, key[8*i +: 8]};
         h = h * MIX_MUL1;
         h = (h << 15) | (h >> 17);
         h = h * MIX_MUL2;
      end
      return h;
   endfunction

   function automatic rsp_type table_access(req_type r);
      rsp_type o;
      int s, len, idx;
      logic [63:0] key, start;
      bit done;
      s = slots_reg;
      if (s < 1) s = 1;
      if (s > Depth) s = Depth;
      len = r.key_length;
      if (len > 8) len = 8;
      key = (len == 0) ? 64'd0 : (r.key_bytes & (~64'd0 >> (64 - 8*len)));
      start = mix_hash(key, len) % s;
      o = '0;
      o.status = (r.operation == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
      done = 1'b0;
      for (longint q = 0; q < s && !done; q++) begin
         idx = int'((start + q*q) % s);
         if (!tbl_valid[idx]) begin
            if (r.operation == OP_INSERT) begin
               tbl_valid[idx] = 1'b1;
               tbl_key[idx] = key;
               tbl_len[idx] = len[3:0];
               tbl_value[idx] = r.value_word;
               tbl_count++;
               o.status = ST_INSERTED;
               o.slot_index = idx[9:0];
            end
            done = 1'b1;
         end else if (r.operation == OP_LOOKUP && tbl_len[idx] == len && tbl_key[idx] == key)
            begin
            o.status = ST_FOUND;
            o.slot_index = idx[9:0];
            o.found_value = tbl_value[idx];
            done = 1'b1;
         end
      end
      o.stored_count = tbl_count[10:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || (req_valid && req_ready_seen)) begin
            if (pending_requests.size() > 0 && !hold_sender) begin
               if (burst_left > 0) begin
                  req_data <= pending_requests.pop_front();
                  req_valid <= 1'b1;
                  burst_left--;
               end else if (gap_left > 0) begin
                  req_valid <= 1'b0;
                  gap_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                  req_valid <= 1'b0;
               end
            end else
               req_valid <= 1'b0;
         end
         stall_phase = (stall_phase + 1) % 97;
         rsp_ready <= (stall_phase < 30) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      req_ready_seen <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_responses.push_back(table_access(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0)
               report_mismatch("unexpected response", 64'(rsp_data), 64'd0);
            else begin
               rsp_type e;
               e = expected_responses.pop_front();
               if (rsp_data.status !== e.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(e.status));
               if (rsp_data.slot_index !== e.slot_index)
                  report_mismatch("slot_index", 64'(rsp_data.slot_index), 64'(e.slot_index));
               if (rsp_data.found_value !== e.found_value)
                  report_mismatch("found_value", 64'(rsp_data.found_value),
                                  64'(e.found_value));
               if (rsp_data.stored_count !== e.stored_count)
                  report_mismatch("stored_count", 64'(rsp_data.stored_count),
                                  64'(e.stored_count));
            end
         end
      end
      if (cycles > CycleLimit) begin
         $display("timeout");
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic req_type make_request(logic op, logic [63:0] key, logic [3:0] len,
                                            logic [31:0] value);
      req_type r;
      r.operation = op;
      r.key_bytes = key;
      r.key_length = len;
      r.value_word = value;
      return r;
   endfunction

   function automatic logic [63:0] random_key();
      return {$urandom(), $urandom()};
   endfunction

   task automatic drain();
      while (pending_requests.size() > 0 || req_valid) @(posedge clock);
      while (expected_responses.size() > 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic write_size(logic [10:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      slots_reg = value;
   endtask

   task automatic queue_random(int n, int key_pool);
      logic [63:0] k;
      logic [3:0] l;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5 || recent_keys.size() == 0) begin
            k = (key_pool > 0) ? 64'($urandom_range(0, key_pool)) : random_key();
            l = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 8));
            recent_keys.push_back(k);
            recent_lens.push_back(l);
            pending_requests.push_back(make_request(OP_INSERT, k, l, $urandom()));
         end else if (pick < 9) begin
            int j;
            j = $urandom_range(0, recent_keys.size() - 1);
            k = recent_keys[j];
            if ($urandom_range(0, 3) == 0) k = k ^ (random_key() << 8*recent_lens[j]);
            pending_requests.push_back(make_request(OP_LOOKUP, k, recent_lens[j],
                                                    $urandom()));
         end else
            pending_requests.push_back(make_request(OP_LOOKUP, random_key(),
                                                    4'($urandom_range(0, 15)), $urandom()));
      end
   endtask

   initial begin
      for (int i = 0; i < Depth; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_key[i] = '0;
         tbl_len[i] = '0;
         tbl_value[i] = '0;
      end
      tbl_count = 0;
      slots_reg = 11'd1024;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, default size
      pending_requests.push_back(make_request(OP_LOOKUP, 64'd0, 4'd0, 32'd0));
      pending_requests.push_back(make_request(OP_INSERT, 64'd0, 4'd0, 32'hFFFF_FFFF));
      pending_requests.push_back(make_request(OP_LOOKUP, ~64'd0, 4'd0, 32'd0));
      pending_requests.push_back(make_request(OP_INSERT, ~64'd0, 4'd8, 32'h1234_5678));
      pending_requests.push_back(make_request(OP_LOOKUP, ~64'd0, 4'd15, ~32'd0));
      pending_requests.push_back(make_request(OP_INSERT, 64'hA5, 4'd1, 32'd0));
      pending_requests.push_back(make_request(OP_LOOKUP, 64'hFFFF_00A5, 4'd1, 32'd0));
      pending_requests.push_back(make_request(OP_LOOKUP, 64'hA5, 4'd2, 32'd0));
      pending_requests.push_back(make_request(OP_INSERT, 64'hA5, 4'd1, 32'hDEAD_BEEF));
      pending_requests.push_back(make_request(OP_LOOKUP, 64'hA5, 4'd1, 32'd0));
      hold_sender = 1'b0;
      drain();

      // size 1: fill then full
      write_size(11'd0);
      pending_requests.push_back(make_request(OP_INSERT, 64'h11, 4'd1, 32'd7));
      pending_requests.push_back(make_request(OP_LOOKUP, 64'h22, 4'd1, 32'd0));
      drain();
      write_size(11'd1);
      pending_requests.push_back(make_request(OP_INSERT, 64'h33, 4'd1, 32'd9));
      pending_requests.push_back(make_request(OP_LOOKUP, 64'h11, 4'd1, 32'd0));
      drain();

      // random traffic at sizes 7, 2047 (clamped to the depth), 13 and 1024; 7 and 13 fill to full
      write_size(11'd7);
      recent_keys.delete(); recent_lens.delete();
      queue_random(60, 0);
      drain();
      write_size(11'd2047);
      queue_random(250, 40);
      drain();
      write_size(11'd13);
      queue_random(80, 0);
      repeat (2000) @(posedge clock);
      hold_sender = 1'b1;
      while (expected_responses.size() > 0 || req_valid) @(posedge clock);
      repeat (50) @(posedge clock);
      hold_sender = 1'b0;
      drain();
      write_size(11'd1024);
      queue_random(330, 0);
      drain();

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

[files.f]
hdl/hktqp_pkg.sv
hdl/hashed_key_table_quadratic_probe.sv
bench/hashed_key_table_quadratic_probe_test.sv
